>>> rtl/core/mmdps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmdps_pkg
// shared constants and sequencer states for the gap point search
// ----------------------------------------------------------------------------
package mmdps_pkg;

    localparam int MAX_ITEMS = 1024;
    localparam int VAL_W     = 31;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    localparam logic CFG_RANGE_LOW  = 1'b0;
    localparam logic CFG_RANGE_HIGH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CHK,
        ST_SEARCH,
        ST_SCAN_RD,
        ST_SCAN_USE,
        ST_FINISH
    } state_t;

endpackage
`default_nettype wire

>>> rtl/core/max_min_distance_point_search_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// max_min_distance_point_search_top
// loads point words into a sorted store and, on the last word, picks the
// in-range point farthest from every stored value
// ----------------------------------------------------------------------------
//  channel   signals                               handshake
//  input     start, point_value, last_value        taken when start & !busy
//  result    done, best_point, best_distance,      one-cycle strobe on done
//            no_point
//  config    cfg_we, cfg_index, cfg_data           taken when cfg_we
//
//  a load word is placed by insertion: every stored value larger than it
//  is read and shifted up one slot, all through the single ram read port
//  a last word then adds a scan that reads every stored value once
//  an empty range answers from ST_SEARCH after the insertion, without a scan
//  reset clears the count and sets the full range, the store needs no clear
//  results cannot be stalled; busy stays high until the strobe cycle
// ----------------------------------------------------------------------------
module max_min_distance_point_search_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [mmdps_pkg::VAL_W-1:0] point_value,
    input  wire logic                       last_value,
    output logic                            done,
    output logic      [mmdps_pkg::VAL_W-1:0] best_point,
    output logic      [mmdps_pkg::VAL_W-1:0] best_distance,
    output logic                            no_point,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [mmdps_pkg::VAL_W-1:0] cfg_data
);
    import mmdps_pkg::*;

    state_t state_reg, state_next;

    logic [VAL_W-1:0]  lo_reg, hi_reg;
    logic [VAL_W-1:0]  v_reg, v_next;
    logic              last_reg, last_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;      // insert slot or scan index
    logic [VAL_W-1:0]  prev_reg, prev_next;
    logic [VAL_W-1:0]  dlo_reg, dlo_next;      // nearest distance to range low
    logic [VAL_W-1:0]  dhi_reg, dhi_next;      // nearest distance to range high
    logic              mval_reg, mval_next;    // a midpoint was in range
    logic [VAL_W-1:0]  mbp_reg, mbp_next;
    logic [VAL_W-1:0]  mbd_reg, mbd_next;
    logic              done_next, nop_next;
    logic [VAL_W-1:0]  bp_next, bd_next;

    // ram port signals
    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [VAL_W-1:0]  wdata, rdata;

    // scan datapath
    logic [VAL_W-1:0]  a, dl, dh, gap, mid, dm;
    logic [VAL_W-1:0]  fbp, fbd;

    mmdps_ram #(
        .DEPTH  (MAX_ITEMS),
        .DATA_W (VAL_W)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign busy = (state_reg != ST_IDLE);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg <= '0;
            hi_reg <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RANGE_LOW:  lo_reg <= cfg_data;
                CFG_RANGE_HIGH: hi_reg <= cfg_data;
                default:        lo_reg <= lo_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            done          <= 1'b0;
            no_point      <= 1'b0;
            best_point    <= '0;
            best_distance <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            done          <= done_next;
            no_point      <= nop_next;
            best_point    <= bp_next;
            best_distance <= bd_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        last_reg <= last_next;
        idx_reg  <= idx_next;
        prev_reg <= prev_next;
        dlo_reg  <= dlo_next;
        dhi_reg  <= dhi_next;
        mval_reg <= mval_next;
        mbp_reg  <= mbp_next;
        mbd_reg  <= mbd_next;
    end

    // shared scan unit: distances to range ends and the gap midpoint
    always_comb
    begin
        a   = rdata;
        dl  = (a > lo_reg) ? a - lo_reg : lo_reg - a;
        dh  = (a > hi_reg) ? a - hi_reg : hi_reg - a;
        gap = a - prev_reg;
        dm  = gap >> 1;
        mid = prev_reg + dm;
    end

    // final pick: range low, then range high, then best midpoint
    always_comb
    begin
        fbp = lo_reg;
        fbd = dlo_reg;
        if (dhi_reg > fbd || (dhi_reg == fbd && hi_reg < fbp))
        begin
            fbp = hi_reg;
            fbd = dhi_reg;
        end
        if (mval_reg && (mbd_reg > fbd || (mbd_reg == fbd && mbp_reg < fbp)))
        begin
            fbp = mbp_reg;
            fbd = mbd_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        v_next     = v_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        prev_next  = prev_reg;
        dlo_next   = dlo_reg;
        dhi_next   = dhi_reg;
        mval_next  = mval_reg;
        mbp_next   = mbp_reg;
        mbd_next   = mbd_reg;
        done_next  = 1'b0;
        nop_next   = no_point;
        bp_next    = best_point;
        bd_next    = best_distance;
        we         = 1'b0;
        waddr      = idx_reg[ADDR_W-1:0];
        wdata      = v_reg;
        raddr      = idx_reg[ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    v_next    = point_value;
                    last_next = last_value;
                    idx_next  = count_reg;
                    if (count_reg >= CNT_W'(MAX_ITEMS))
                    begin
                        state_next = last_value ? ST_SEARCH : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_INS_RD;
                    end
                end
            end
            ST_INS_RD:
            begin
                raddr = idx_reg[ADDR_W-1:0] - 1'b1;
                if (idx_reg == '0)
                begin
                    we         = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = last_reg ? ST_SEARCH : ST_IDLE;
                end
                else
                begin
                    state_next = ST_INS_CHK;
                end
            end
            ST_INS_CHK:
            begin
                we = 1'b1;
                if (rdata > v_reg)
                begin
                    // shift the larger value up one slot
                    wdata      = rdata;
                    idx_next   = idx_reg - 1'b1;
                    state_next = ST_INS_RD;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    state_next = last_reg ? ST_SEARCH : ST_IDLE;
                end
            end
            ST_SEARCH:
            begin
                idx_next  = '0;
                mval_next = 1'b0;
                if (lo_reg > hi_reg)
                begin
                    done_next  = 1'b1;
                    nop_next   = 1'b1;
                    bp_next    = '0;
                    bd_next    = '0;
                    count_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_USE;
            end
            ST_SCAN_USE:
            begin
                prev_next = a;
                if (idx_reg == '0)
                begin
                    dlo_next = dl;
                    dhi_next = dh;
                end
                else
                begin
                    if (dl < dlo_reg)
                    begin
                        dlo_next = dl;
                    end
                    if (dh < dhi_reg)
                    begin
                        dhi_next = dh;
                    end
                    if (mid >= lo_reg && mid <= hi_reg &&
                        (!mval_reg || dm > mbd_reg || (dm == mbd_reg && mid < mbp_reg)))
                    begin
                        mval_next = 1'b1;
                        mbp_next  = mid;
                        mbd_next  = dm;
                    end
                end
                idx_next   = idx_reg + 1'b1;
                state_next = (idx_reg + 1'b1 == count_reg) ? ST_FINISH : ST_SCAN_RD;
            end
            ST_FINISH:
            begin
                done_next  = 1'b1;
                nop_next   = 1'b0;
                bp_next    = fbp;
                bd_next    = fbd;
                count_next = '0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("value count above store depth");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && count_reg == '0)
        else $error("result word while still busy or count not cleared");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN_USE |-> idx_reg < count_reg)
        else $error("scan index past stored values");

endmodule
`default_nettype wire

>>> rtl/core/mmdps_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmdps_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module mmdps_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 31
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> tb/gap_search_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_search_checker
// watches the load, result and register channels of the gap point search,
// keeps its own sorted copy of each loaded set and compares every answer
// ----------------------------------------------------------------------------
module gap_search_checker
    import mmdps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic [VAL_W-1:0] point_value,
    input  logic             last_value,
    input  logic             done,
    input  logic [VAL_W-1:0] best_point,
    input  logic [VAL_W-1:0] best_distance,
    input  logic             no_point,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [VAL_W-1:0] cfg_data,
    output int               fail_count,
    output int               pending,
    output int               answers_seen,
    output int               empty_seen
);

    typedef struct packed {
        logic [VAL_W-1:0] point;
        logic [VAL_W-1:0] distance;
        logic             empty;
    } gap_answer_t;

    logic [VAL_W-1:0] sorted_set[$];
    logic [VAL_W-1:0] low_reg;
    logic [VAL_W-1:0] high_reg;
    gap_answer_t      answers_due[$];

    function automatic logic [VAL_W-1:0] dist_of(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [VAL_W-1:0] nearest(logic [VAL_W-1:0] x);
        logic [VAL_W-1:0] d;
        d = dist_of(sorted_set[0], x);
        foreach (sorted_set[k])
            if (dist_of(sorted_set[k], x) < d)
                d = dist_of(sorted_set[k], x);
        return d;
    endfunction

    function automatic void add_value(logic [VAL_W-1:0] v);
        int pos;
        if (sorted_set.size() >= MAX_ITEMS)
            return;
        pos = sorted_set.size();
        while (pos > 0 && sorted_set[pos-1] > v)
            pos--;
        sorted_set.insert(pos, v);
    endfunction

    function automatic gap_answer_t widest_gap();
        gap_answer_t      r;
        logic [VAL_W-1:0] d;
        logic [VAL_W:0]   sum;
        logic [VAL_W-1:0] mid;
        r = '0;
        if (low_reg > high_reg) begin
            r.empty = 1'b1;
            return r;
        end
        r.point    = low_reg;
        r.distance = nearest(low_reg);
        d = nearest(high_reg);
        if (d > r.distance || (d == r.distance && high_reg < r.point)) begin
            r.point    = high_reg;
            r.distance = d;
        end
        for (int k = 0; k + 1 < sorted_set.size(); k++) begin
            sum = {1'b0, sorted_set[k]} + {1'b0, sorted_set[k+1]};
            mid = sum[VAL_W:1];
            if (mid >= low_reg && mid <= high_reg) begin
                d = (mid - sorted_set[k] < sorted_set[k+1] - mid) ?
                    mid - sorted_set[k] : sorted_set[k+1] - mid;
                if (d > r.distance || (d == r.distance && mid < r.point)) begin
                    r.point    = mid;
                    r.distance = d;
                end
            end
        end
        return r;
    endfunction

    assign pending = answers_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        gap_answer_t want;
        if (!rst_n) begin
            sorted_set.delete();
            answers_due.delete();
            low_reg      <= '0;
            high_reg     <= '1;
            fail_count   <= 0;
            answers_seen <= 0;
            empty_seen   <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_RANGE_LOW)
                    low_reg <= cfg_data;
                else
                    high_reg <= cfg_data;
            end
            if (start && !busy) begin
                add_value(point_value);
                if (last_value) begin
                    answers_due.push_back(widest_gap());
                    sorted_set.delete();
                end
            end
            if (done) begin
                answers_seen <= answers_seen + 1;
                if (no_point)
                    empty_seen <= empty_seen + 1;
                if (answers_due.size() == 0) begin
                    $error("unexpected result word: point %0d distance %0d no_point %0d",
                           best_point, best_distance, no_point);
                    fail_count <= fail_count + 1;
                end else begin
                    want = answers_due.pop_front();
                    if (best_point !== want.point || best_distance !== want.distance ||
                        no_point !== want.empty)
                        fail_count <= fail_count + 1;
                    if (best_point !== want.point)
                        $error("best_point: expected %0d, got %0d", want.point, best_point);
                    if (best_distance !== want.distance)
                        $error("best_distance: expected %0d, got %0d",
                               want.distance, best_distance);
                    if (no_point !== want.empty)
                        $error("no_point: expected %0d, got %0d", want.empty, no_point);
                end
            end
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives point sets and range settings into the gap point search; a checker
// beside the block predicts each answer and counts mismatches
// ----------------------------------------------------------------------------
module tb_top;
    import mmdps_pkg::*;

    // cycles with no word, result or register write before giving up
    localparam int WATCHDOG_LIMIT = 30000;
    localparam int WORD_TARGET    = 1350;
    localparam logic [VAL_W-1:0] TOP_VAL = '1;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [VAL_W-1:0] point_value;
    logic             last_value;
    logic             done;
    logic [VAL_W-1:0] best_point;
    logic [VAL_W-1:0] best_distance;
    logic             no_point;
    logic             cfg_we;
    logic             cfg_index;
    logic [VAL_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int answers_seen;
    int empty_seen;
    int words_sent;
    int burst_left;
    int quiet_cycles;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    max_min_distance_point_search_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .point_value  (point_value),
        .last_value   (last_value),
        .done         (done),
        .best_point   (best_point),
        .best_distance(best_distance),
        .no_point     (no_point),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    gap_search_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .point_value  (point_value),
        .last_value   (last_value),
        .done         (done),
        .best_point   (best_point),
        .best_distance(best_distance),
        .no_point     (no_point),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .answers_seen (answers_seen),
        .empty_seen   (empty_seen)
    );

    // watchdog: any accepted word, result or register write resets it
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((start && !busy) || done || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    // every task below is entered just after a rising edge and leaves just
    // after one, so start never gets two assignments in one step
    task automatic new_burst();
        // now and then a long stretch with no sender gaps at all
        burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 40);
    endtask

    task automatic send_word(logic [VAL_W-1:0] v, logic is_last);
        start       <= 1'b1;
        point_value <= v;
        last_value  <= is_last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        words_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            // random gap between bursts, start stays low for it
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            new_burst();
        end
    endtask

    // hold the sender until every answer is back, then a few spare cycles
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // registers only change once the block is idle
    task automatic set_range(logic [VAL_W-1:0] lo, logic [VAL_W-1:0] hi);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RANGE_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= CFG_RANGE_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value(int flavor);
        case (flavor)
            0:       return VAL_W'($urandom_range(0, 40));
            1:       return TOP_VAL - VAL_W'($urandom_range(0, 40));
            2:       return VAL_W'($urandom_range(0, 5000));
            default: return VAL_W'($urandom());
        endcase
    endfunction

    task automatic send_set(int count, int flavor);
        for (int i = 0; i < count; i++)
            send_word(pick_value(flavor), i == count - 1);
    endtask

    task automatic random_range();
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
        a = VAL_W'($urandom());
        b = VAL_W'($urandom());
        case ($urandom_range(0, 6))
            0: set_range('0, TOP_VAL);
            1: set_range((a < b) ? a : b, (a < b) ? b : a);
            2: set_range((a > b) ? a : b, (a > b) ? b : a + 1'b0);
            3: set_range(a, a);
            4: set_range(VAL_W'($urandom_range(0, 20)), VAL_W'($urandom_range(20, 6000)));
            5: set_range(TOP_VAL - VAL_W'($urandom_range(0, 30)), TOP_VAL);
            default: set_range('0, VAL_W'($urandom_range(0, 60)));
        endcase
    endtask

    initial
    begin
        int sets_done;
        rst_n        = 1'b0;
        start        = 1'b0;
        point_value  = '0;
        last_value   = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_RANGE_LOW;
        cfg_data     = '0;
        quiet_cycles = 0;
        words_sent   = 0;
        sets_done    = 0;
        new_burst();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset range, single values at both extremes
        send_word(TOP_VAL, 1'b1);
        send_word('0, 1'b1);
        // extremes together, midpoint in the middle of the full range
        send_word('0, 1'b0);
        send_word(TOP_VAL, 1'b1);
        // duplicates: the gaps between them are empty, so a range end wins
        send_word(100, 1'b0);
        send_word(100, 1'b0);
        send_word(100, 1'b1);
        // narrow range, both midpoints outside it
        set_range(50, 60);
        send_word(55, 1'b0);
        send_word(10, 1'b0);
        send_word(200, 1'b1);
        // empty range
        set_range(10, 5);
        send_word(3, 1'b1);
        // single point range at the top, and at zero
        set_range(TOP_VAL, TOP_VAL);
        send_word(5, 1'b1);
        set_range('0, '0);
        send_word(0, 1'b0);
        send_word(9, 1'b1);
        // tie between two equal gaps picks the smaller point
        set_range('0, 40);
        send_word(0, 1'b0);
        send_word(40, 1'b0);
        send_word(20, 1'b1);

        // overflowing set: ascending so insertion stays cheap, the marked
        // word lands past the store limit and is dropped but still searches
        set_range('0, TOP_VAL);
        for (int i = 0; i < MAX_ITEMS + 6; i++)
            send_word(VAL_W'(i * 2000003), i == MAX_ITEMS + 5);

        // random sets, mostly small, with range changes between phases
        while (words_sent < WORD_TARGET) begin
            if (sets_done % 12 == 0)
                random_range();
            send_set(($urandom_range(0, 7) == 0) ? $urandom_range(1, 60) :
                     $urandom_range(1, 12), $urandom_range(0, 4));
            sets_done++;
        end

        drain();
        repeat (20) @(posedge clk);
        $display("covered %0d words in %0d answers, %0d of them with an empty range",
                 words_sent, answers_seen, empty_seen);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
